// File: src/dttr_pkg.sv
// Shared types, codes and the tool code lookup for the tablet report decoder.
package dttr_pkg;

  localparam logic [7:0] ReportIdTablet = 8'd2;

  // Report kinds on the result tuser.
  localparam logic [3:0] KIND_ENTER = 4'd0;
  localparam logic [3:0] KIND_EXIT  = 4'd1;
  localparam logic [3:0] KIND_PEN   = 4'd2;
  localparam logic [3:0] KIND_AIR2  = 4'd3;
  localparam logic [3:0] KIND_ROT   = 4'd4;
  localparam logic [3:0] KIND_M4D   = 4'd5;
  localparam logic [3:0] KIND_M2D   = 4'd6;
  localparam logic [3:0] KIND_LENS  = 4'd7;
  localparam logic [3:0] KIND_COORD = 4'd8;

  // Tool kinds kept per slot.
  localparam logic [2:0] TK_PEN      = 3'd0;
  localparam logic [2:0] TK_PENCIL   = 3'd1;
  localparam logic [2:0] TK_BRUSH    = 3'd2;
  localparam logic [2:0] TK_MOUSE    = 3'd3;
  localparam logic [2:0] TK_LENS     = 3'd4;
  localparam logic [2:0] TK_ERASER   = 3'd5;
  localparam logic [2:0] TK_AIRBRUSH = 3'd6;
  localparam logic [2:0] TK_NONE     = 3'd7;

  localparam logic [9:0] TouchThreshold = 10'd10;

  // Input report; the last member sits in the lowest bits of tdata.
  typedef struct packed {
    logic [7:0] byte9;
    logic [7:0] byte8;
    logic [7:0] byte7;
    logic [7:0] byte6;
    logic [7:0] byte5;
    logic [7:0] byte4;
    logic [7:0] byte3;
    logic [7:0] byte2;
    logic [7:0] status_byte;
    logic [7:0] report_id;
  } report_t;

  // Decoded record body; the last member sits in the lowest bits of tdata.
  typedef struct packed {
    logic signed [10:0] signed_value;
    logic [7:0]         button_bits;
    logic [6:0]         tilt_vertical;
    logic [6:0]         tilt_horizontal;
    logic [9:0]         pressure_or_wheel;
    logic [3:0]         hover_distance;
    logic [15:0]        pos_y;
    logic [15:0]        pos_x;
    logic [24:0]        tool_serial;
    logic [2:0]         tool_kind;
    logic               tool_slot;
  } body_t;

  typedef struct packed {
    logic [3:0] report_kind;
    body_t      body;
  } rec_t;

  // Slot store write request.
  typedef struct packed {
    logic        we;
    logic        slot;
    logic [2:0]  kind;
    logic [24:0] serial;
  } slot_wr_t;

  // Slot store read data.
  typedef struct packed {
    logic [2:0]  kind;
    logic [24:0] serial;
  } slot_rd_t;

  function automatic logic [2:0] map_tool(input logic [11:0] code);
    logic [2:0] k;
    case (code)
      12'h812, 12'h012:                         k = TK_PENCIL;
      12'h832, 12'h032:                         k = TK_BRUSH;
      12'h007, 12'h09C, 12'h094:                k = TK_MOUSE;
      12'h096:                                  k = TK_LENS;
      12'h82A, 12'h85A, 12'h91A, 12'hD1A, 12'h0FA: k = TK_ERASER;
      12'h112, 12'h912, 12'hD12:                k = TK_AIRBRUSH;
      default:                                  k = TK_PEN;
    endcase
    return k;
  endfunction

endpackage

// File: src/dttr_slots.sv
// Per-slot tool kind and serial number store for the two tracked tools.
module dttr_slots (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dttr_pkg::slot_wr_t wr_i,
  input  logic              rd_slot_i,
  output dttr_pkg::slot_rd_t rd_o
);
  import dttr_pkg::*;

  logic [1:0][2:0]  kind_q;
  logic [1:0][24:0] serial_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= {2{TK_NONE}};
      serial_q <= '0;
    end else if (wr_i.we) begin
      kind_q[wr_i.slot]   <= wr_i.kind;
      serial_q[wr_i.slot] <= wr_i.serial;
    end
  end

  assign rd_o.kind   = kind_q[rd_slot_i];
  assign rd_o.serial = serial_q[rd_slot_i];

endmodule

// File: src/dttr_decode.sv
// Single-pass field decode of one registered tablet report.
module dttr_decode (
  input  logic               err_i,
  input  dttr_pkg::report_t  rpt_i,
  input  dttr_pkg::slot_rd_t slot_rd_i,
  output logic               keep_o,
  output dttr_pkg::rec_t     rec_o,
  output dttr_pkg::slot_wr_t upd_o
);
  import dttr_pkg::*;

  logic [7:0]  st;
  logic [9:0]  v;
  logic [24:0] serial;
  logic        is_enter;
  logic        is_exit;
  logic        is_stylus;
  logic        is_puck;

  assign st = rpt_i.status_byte;
  assign v  = {rpt_i.byte6, rpt_i.byte7[7:6]};

  // The serial bits overlap, so they are summed rather than concatenated.
  assign serial = 25'({rpt_i.byte3[3:0], 4'b0000}) + 25'({rpt_i.byte4, 16'h0000})
                + 25'({rpt_i.byte5, 12'h000}) + 25'({rpt_i.byte6, 4'b0000})
                + 25'(rpt_i.byte7[7:4]);

  assign keep_o    = !err_i && (rpt_i.report_id == ReportIdTablet);
  assign is_enter  = (st[7:2] == 6'b110000);
  assign is_exit   = (st[7:1] == 7'b1000000);
  assign is_stylus = ((st & 8'hb8) == 8'ha0) || ((st & 8'hbc) == 8'hb4);
  assign is_puck   = ((st & 8'hbc) == 8'ha8) || ((st & 8'hbe) == 8'hb0);

  assign upd_o.we     = keep_o && is_enter;
  assign upd_o.slot   = st[0];
  assign upd_o.kind   = map_tool({rpt_i.byte2, rpt_i.byte3[7:4]});
  assign upd_o.serial = serial;

  always_comb begin
    rec_o                  = '0;
    rec_o.report_kind      = KIND_COORD;
    rec_o.body.tool_slot   = st[0];
    rec_o.body.tool_kind   = slot_rd_i.kind;
    rec_o.body.tool_serial = slot_rd_i.serial;
    if (is_enter) begin
      rec_o.report_kind      = KIND_ENTER;
      rec_o.body.tool_kind   = upd_o.kind;
      rec_o.body.tool_serial = serial;
    end else if (is_exit) begin
      rec_o.report_kind = KIND_EXIT;
    end else begin
      rec_o.body.pos_x          = {rpt_i.byte2, rpt_i.byte3};
      rec_o.body.pos_y          = {rpt_i.byte4, rpt_i.byte5};
      rec_o.body.hover_distance = rpt_i.byte9[7:4];
      if (is_stylus) begin
        rec_o.body.pressure_or_wheel = v;
        rec_o.body.tilt_horizontal   = {rpt_i.byte7[5:0], rpt_i.byte8[7]};
        rec_o.body.tilt_vertical     = rpt_i.byte8[6:0];
        if ((st & 8'hb8) == 8'ha0) begin
          rec_o.report_kind      = KIND_PEN;
          rec_o.body.button_bits = {5'b00000, st[2], st[1], (v > TouchThreshold)};
        end else begin
          rec_o.report_kind = KIND_AIR2;
        end
      end else if (is_puck) begin
        if (st[1]) begin
          rec_o.report_kind = KIND_ROT;
          // Negative rotation is reported as -v-1, which is the bitwise inverse.
          rec_o.body.signed_value = rpt_i.byte7[5] ? {1'b0, v} : ~{1'b0, v};
        end else if (!st[4]) begin
          rec_o.report_kind      = KIND_M4D;
          rec_o.body.button_bits = {rpt_i.byte8[4], rpt_i.byte8[5], rpt_i.byte8[2],
                                    rpt_i.byte8[1], rpt_i.byte8[0], 3'b000};
          if (rpt_i.byte8[3]) begin
            rec_o.body.signed_value = 11'd0 - {1'b0, v};
          end else begin
            rec_o.body.signed_value = {1'b0, rpt_i.byte6, 2'b00}
                                    - {9'd0, rpt_i.byte7[7:6]};
          end
        end else if (slot_rd_i.kind == TK_MOUSE) begin
          rec_o.report_kind       = KIND_M2D;
          rec_o.body.button_bits  = {2'b00, rpt_i.byte8[4], rpt_i.byte8[3],
                                     rpt_i.byte8[2], 3'b000};
          rec_o.body.signed_value = {10'd0, rpt_i.byte8[1]} - {10'd0, rpt_i.byte8[0]};
        end else begin
          rec_o.report_kind      = KIND_LENS;
          rec_o.body.button_bits = {rpt_i.byte8[3], rpt_i.byte8[4], rpt_i.byte8[2],
                                    rpt_i.byte8[1], rpt_i.byte8[0], 3'b000};
        end
      end
    end
  end

endmodule

// File: src/dual_tool_tablet_report_decoder_top.sv
// An accepted input beat passes the input register, then the result register, to its result beat.
// One report per cycle unless stalled; the slot store is read and written in the decode cycle.
// Reports with a transfer error or a foreign report id leave the pipeline without a result beat.
// Reset clears both valid flags and sets both tool slots to no tool with serial zero.
// Back-pressure on the result side stalls the input register, which then stalls the input.
module dual_tool_tablet_report_decoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // report_id, status_byte, byte2 .. byte9
  input  logic [79:0]  s_axis_tdata_i,
  // transfer_error
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tool_slot, tool_kind, tool_serial, pos_x, pos_y, hover_distance, pressure_or_wheel,
  // tilt_horizontal, tilt_vertical, button_bits, signed_value, 4 zero bits
  output logic [111:0] m_axis_tdata_o,
  // report_kind
  output logic [3:0]   m_axis_tuser_o
);
  import dttr_pkg::*;

  logic     in_valid_q;
  logic     in_err_q;
  report_t  in_rpt_q;
  logic     out_valid_q;
  rec_t     out_q;

  logic     keep;
  logic     out_free;
  logic     advance;
  rec_t     rec;
  slot_wr_t upd;
  slot_wr_t slot_wr;
  slot_rd_t slot_rd;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!keep || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_err_q <= s_axis_tuser_i[0];
      in_rpt_q <= report_t'(s_axis_tdata_i);
    end
  end

  dttr_decode u_decode (
    .err_i     (in_err_q),
    .rpt_i     (in_rpt_q),
    .slot_rd_i (slot_rd),
    .keep_o    (keep),
    .rec_o     (rec),
    .upd_o     (upd)
  );

  // The store is written on the same edge the enter beat moves to the result register.
  always_comb begin
    slot_wr    = upd;
    slot_wr.we = upd.we && advance;
  end

  dttr_slots u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (slot_wr),
    .rd_slot_i (in_rpt_q.status_byte[0]),
    .rd_o      (slot_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && keep) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && keep) begin
      out_q <= rec;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.report_kind;
  assign m_axis_tdata_o  = {4'b0000, out_q.body};

  a_keep_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && keep) |=> m_axis_tvalid_o)
    else $error("kept report did not reach the result register");

  a_no_tool_no_serial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_rd.kind == TK_NONE) |-> (slot_rd.serial == 25'd0))
    else $error("slot without a tool holds a serial number");

  a_enter_has_tool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KIND_ENTER)) |-> (out_q.body.tool_kind != TK_NONE))
    else $error("enter record carries no tool");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && keep && !out_free) |=> (in_valid_q && $stable(in_rpt_q)))
    else $error("input register changed while the result side stalled");

endmodule

// File: tb/tb_dual_tool_tablet_report_decoder_top.sv
// Self-checking testbench for the dual-tool tablet report decoder with a record scoreboard.
module tb_dual_tool_tablet_report_decoder_top;
  import dttr_pkg::*;

  // Predicts decoded records from accepted reports and checks result beats against them.
  class tablet_scoreboard;
    rec_t       expected_records[$];
    logic [2:0] slot_kind[2];
    logic [24:0] slot_serial[2];
    int         errors;

    function new();
      slot_kind[0]   = TK_NONE;
      slot_kind[1]   = TK_NONE;
      slot_serial[0] = '0;
      slot_serial[1] = '0;
      errors         = 0;
    endfunction

    function logic [2:0] tool_for_code(logic [11:0] code);
      logic [2:0] k;
      k = TK_PEN;
      case (code)
        12'h012, 12'h812: k = TK_PENCIL;
        12'h032, 12'h832: k = TK_BRUSH;
        12'h007, 12'h094, 12'h09C: k = TK_MOUSE;
        12'h096: k = TK_LENS;
        12'h0FA, 12'h82A, 12'h85A, 12'h91A, 12'hD1A: k = TK_ERASER;
        12'h112, 12'h912, 12'hD12: k = TK_AIRBRUSH;
        default: k = TK_PEN;
      endcase
      return k;
    endfunction

    function void note_input(report_t r, bit err);
      rec_t        e;
      logic        s;
      logic [9:0]  v;
      logic [31:0] sum;
      if (err || r.report_id != ReportIdTablet) return;
      s = r.status_byte[0];
      e = '0;
      e.body.tool_slot = s;
      v = {r.byte6, r.byte7[7:6]};
      casez (r.status_byte)
        8'b1100_00??: begin
          sum = (32'(r.byte4) << 16) + (32'(r.byte5) << 12) + (32'(r.byte6) << 4)
              + 32'(r.byte7[7:4]) + 32'(r.byte3[3:0]) * 16;
          slot_serial[s] = sum[24:0];
          slot_kind[s]   = tool_for_code({r.byte2, r.byte3[7:4]});
          e.report_kind  = KIND_ENTER;
        end
        8'b1000_000?: e.report_kind = KIND_EXIT;
        default: begin
          e.body.pos_x          = {r.byte2, r.byte3};
          e.body.pos_y          = {r.byte4, r.byte5};
          e.body.hover_distance = r.byte9[7:4];
          e.report_kind         = KIND_COORD;
          casez (r.status_byte)
            8'b1?10_0???, 8'b1?11_01??: begin
              e.report_kind = r.status_byte[4] ? KIND_AIR2 : KIND_PEN;
              e.body.pressure_or_wheel = v;
              e.body.tilt_horizontal   = {r.byte7[5:0], r.byte8[7]};
              e.body.tilt_vertical     = r.byte8[6:0];
              if (e.report_kind == KIND_PEN)
                e.body.button_bits = {5'b0, r.status_byte[2:1], v > TouchThreshold};
            end
            8'b1?10_10??, 8'b1?11_000?: begin
              if (r.status_byte[1]) begin
                e.report_kind = KIND_ROT;
                // Without the sign bit the value is minus v minus one, which is just ~v.
                e.body.signed_value = r.byte7[5] ? 11'(v) : ~11'(v);
              end else if (!r.status_byte[4]) begin
                e.report_kind = KIND_M4D;
                e.body.button_bits = {r.byte8[4], r.byte8[5], r.byte8[2:0], 3'b0};
                e.body.signed_value = r.byte8[3] ? 11'(0) - 11'(v)
                                    : 11'({r.byte6, 2'b00}) - 11'(r.byte7[7:6]);
              end else if (slot_kind[s] == TK_MOUSE) begin
                e.report_kind = KIND_M2D;
                e.body.button_bits = {2'b0, r.byte8[4:2], 3'b0};
                e.body.signed_value = 11'(r.byte8[1]) - 11'(r.byte8[0]);
              end else begin
                e.report_kind = KIND_LENS;
                e.body.button_bits = {r.byte8[3], r.byte8[4], r.byte8[2:0], 3'b0};
              end
            end
            default: ;
          endcase
        end
      endcase
      e.body.tool_kind   = slot_kind[s];
      e.body.tool_serial = slot_serial[s];
      expected_records.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [3:0] kind, logic [111:0] data);
      rec_t  e;
      body_t b;
      if (expected_records.size() == 0) begin
        $error("result beat with no record expected (kind 0x%0h)", kind);
        errors++;
        return;
      end
      e = expected_records.pop_front();
      b = data[107:0];
      compare_field("report_kind", 32'(e.report_kind), 32'(kind));
      compare_field("tool_slot", 32'(e.body.tool_slot), 32'(b.tool_slot));
      compare_field("tool_kind", 32'(e.body.tool_kind), 32'(b.tool_kind));
      compare_field("tool_serial", 32'(e.body.tool_serial), 32'(b.tool_serial));
      compare_field("pos_x", 32'(e.body.pos_x), 32'(b.pos_x));
      compare_field("pos_y", 32'(e.body.pos_y), 32'(b.pos_y));
      compare_field("hover_distance", 32'(e.body.hover_distance), 32'(b.hover_distance));
      compare_field("pressure_or_wheel", 32'(e.body.pressure_or_wheel),
                    32'(b.pressure_or_wheel));
      compare_field("tilt_horizontal", 32'(e.body.tilt_horizontal), 32'(b.tilt_horizontal));
      compare_field("tilt_vertical", 32'(e.body.tilt_vertical), 32'(b.tilt_vertical));
      compare_field("button_bits", 32'(e.body.button_bits), 32'(b.button_bits));
      compare_field("signed_value", 32'(e.body.signed_value), 32'(b.signed_value));
      compare_field("tdata padding", 32'd0, 32'(data[111:108]));
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  bit           clk = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [3:0]   m_tuser;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;

  tablet_scoreboard sb = new();

  logic [11:0] known_codes[17] = '{12'h812, 12'h012, 12'h832, 12'h032, 12'h007, 12'h09C,
                                   12'h094, 12'h096, 12'h82A, 12'h85A, 12'h91A, 12'hD1A,
                                   12'h0FA, 12'h112, 12'h912, 12'hD12, 12'h802};

  dual_tool_tablet_report_decoder_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_ni && s_tvalid && s_tready) sb.note_input(report_t'(s_tdata), s_tuser[0]);
  end

  always @(posedge clk) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Result side: random stall bursts, and one long hold-off so the pipeline backs up.
  always @(negedge clk) begin
    if (!rst_ni) begin
      m_tready = 1'b0;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 199;
      m_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  function automatic report_t pack_report(logic [7:0] id, logic [7:0] st, logic [7:0] b2,
                                          logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                          logic [7:0] b6, logic [7:0] b7, logic [7:0] b8,
                                          logic [7:0] b9);
    report_t r;
    r.report_id   = id;
    r.status_byte = st;
    r.byte2 = b2;
    r.byte3 = b3;
    r.byte4 = b4;
    r.byte5 = b5;
    r.byte6 = b6;
    r.byte7 = b7;
    r.byte8 = b8;
    r.byte9 = b9;
    return r;
  endfunction

  task automatic send_report(input report_t r, input bit err);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = r;
    s_tuser  = err;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_tablet(input logic [7:0] st, input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4, input logic [7:0] b5, input logic [7:0] b6,
                             input logic [7:0] b7, input logic [7:0] b8, input logic [7:0] b9);
    send_report(pack_report(ReportIdTablet, st, b2, b3, b4, b5, b6, b7, b8, b9), 1'b0);
  endtask

  task automatic send_random_report();
    report_t     r;
    logic [11:0] code;
    int          pick;
    bit          err;
    r = report_t'(80'({$urandom, $urandom, $urandom}));
    r.report_id = ($urandom_range(0, 19) == 0) ? 8'($urandom) : ReportIdTablet;
    err = ($urandom_range(0, 32) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.status_byte = 8'hC0 | 8'($urandom_range(0, 3));
      code = ($urandom_range(0, 3) != 0) ? known_codes[$urandom_range(0, 16)] : 12'($urandom);
      r.byte2 = code[11:4];
      r.byte3[7:4] = code[3:0];
    end else if (pick < 20) begin
      r.status_byte = 8'h80 | 8'($urandom_range(0, 1));
    end else if (pick < 45) begin
      r.status_byte = 8'hA0 | 8'($urandom_range(0, 1) << 6) | 8'($urandom_range(0, 7));
    end else if (pick < 55) begin
      r.status_byte = 8'hB4 | 8'($urandom_range(0, 1) << 6) | 8'($urandom_range(0, 3));
    end else if (pick < 65) begin
      r.status_byte = 8'hAA | 8'($urandom_range(0, 1) << 6) | 8'($urandom_range(0, 1));
    end else if (pick < 75) begin
      r.status_byte = 8'hA8 | 8'($urandom_range(0, 1) << 6) | 8'($urandom_range(0, 1));
    end else if (pick < 90) begin
      r.status_byte = 8'hB0 | 8'($urandom_range(0, 1) << 6) | 8'($urandom_range(0, 1));
    end
    // Keep pressure near the touch threshold now and then.
    if ($urandom_range(0, 3) == 0) r.byte6 = 8'($urandom_range(0, 3));
    send_report(r, err);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Dropped reports: transfer error and foreign report ids.
    send_report(pack_report(ReportIdTablet, 8'hA0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC,
                            8'hDE, 8'hF0), 1'b1);
    send_report(pack_report(8'h00, 8'hA0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00), 1'b0);
    send_report(pack_report(8'hFF, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                            8'hFF, 8'hFF), 1'b0);
    // Exit and motion before any tool entered.
    send_tablet(8'h80, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88);
    send_tablet(8'hA7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tablet(8'hB0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h1F, 8'hA0);
    // Statuses that match no motion packet give coordinates only.
    send_tablet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_tablet(8'hFF, 8'hAB, 8'hCD, 8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hF0);
    // Mouse in slot 0 with the largest serial, then 2D wheel steps.
    send_tablet(8'hC0, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'hA5);
    send_tablet(8'hB0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h00, 8'h1D, 8'h30);
    send_tablet(8'hF0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h00, 8'h02, 8'h30);
    // 4D throttle, both signs of the quirky arithmetic.
    send_tablet(8'hA8, 8'h00, 8'h01, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'h3F, 8'h70);
    send_tablet(8'hE8, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'hC0, 8'h37, 8'h70);
    // Rotation with and without the sign bit.
    send_tablet(8'hAA, 8'h10, 8'h20, 8'h30, 8'h40, 8'hFF, 8'hFF, 8'h00, 8'h10);
    send_tablet(8'hAB, 8'h10, 8'h20, 8'h30, 8'h40, 8'h00, 8'h00, 8'h00, 8'h10);
    // Unknown tool code stores pen; then pen at and just above the touch threshold.
    send_tablet(8'hC3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tablet(8'hA1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h02, 8'h80, 8'h81, 8'h20);
    send_tablet(8'hA5, 8'h01, 8'h02, 8'h03, 8'h04, 8'h02, 8'hC0, 8'h7F, 8'h20);
    send_tablet(8'hB5, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hFF, 8'h3F, 8'hFF, 8'hF0);
    // Lens in slot 0 turns the bit-4 packet into a lens packet.
    send_tablet(8'hC0, 8'h09, 8'h63, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h00);
    send_tablet(8'hB0, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h1F, 8'h50);
    send_tablet(8'hC1, 8'hD1, 8'h20, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
    send_tablet(8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_tablet(8'hC2, 8'h0F, 8'hA9, 8'h87, 8'h65, 8'h43, 8'h21, 8'h00, 8'h00);
    send_tablet(8'hE0, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h80);

    hold_req = 1'b1;
    for (int i = 0; i < 1525; i++) begin
      if (i == 1375) quiet = 1'b1;
      send_random_report();
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
